// ===== rtl/core/distinct_index_rejection_sampler_defines.svh =====
// Assertion macros for the distinct index rejection sampler.
// No dependencies; included by the modules that carry assertions.
`ifndef DISTINCT_INDEX_REJECTION_SAMPLER_DEFINES_SVH
`define DISTINCT_INDEX_REJECTION_SAMPLER_DEFINES_SVH
`ifndef ASSERT_OFF
// Clocked check, masked while reset is asserted.
`define DIRS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define DIRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DIRS_ASSERT(lbl, clk, rst_n, prop, msg)
`define DIRS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/dirs_pkg.sv =====
// Shared constants and types for the distinct index rejection sampler.
// No dependencies.
`default_nettype none

package dirs_pkg;

    localparam int DEF_MAX_WEIGHT = 128;
    localparam int DEF_INDEX_BITS = 16;

    // widest values the parameters may take
    localparam int ADDR_MAX_BITS = 10;
    localparam int DATA_MAX_BITS = 32;

    localparam int CFG_ADDR_BITS = 3;

    // register index, taken from paddr[2]
    localparam logic REG_TARGET_WEIGHT = 1'b0;
    localparam logic REG_INDEX_RANGE   = 1'b1;

    localparam logic [7:0]  RST_TARGET_WEIGHT = 8'd71;
    localparam logic [15:0] RST_INDEX_RANGE   = 16'd10163;

    // request from the sequencer to the index store
    typedef struct packed {
        logic                     we;
        logic [ADDR_MAX_BITS-1:0] waddr;
        logic [DATA_MAX_BITS-1:0] wdata;
        logic                     re;
        logic [ADDR_MAX_BITS-1:0] raddr;
    } t_store_req;

endpackage

`default_nettype wire

// ===== rtl/core/distinct_index_rejection_sampler.sv =====
// Top level of the distinct index rejection sampler: APB register file,
// weight/range conditioning, sequencer and index store. Depends on dirs_pkg.
//
//  channel   direction  transaction taken when            payload
//  command   in         start && !busy                     i_random_word
//  result    out        o_strobe (one cycle, no backpress) o_index_value, o_list_slot, o_last
//  config    in         psel && penable && pwrite          paddr, pwdata (reg 0 at 0, reg 1 at 4)
//
// A word outside the range is dropped at the accept edge and busy stays low. Otherwise
// busy holds while the single comparator walks the store one entry at a time, checking
// each entry as the registered read port returns it; a word that repeats the index in a
// slot ends the scan there with no result. The strobe sits in the first cycle busy is low.
// Reset (synchronous, active low) empties the list and restores weight 71, range 10163;
// store contents are left as they are. Results cannot be stalled by the receiver.
`default_nettype none

module distinct_index_rejection_sampler import dirs_pkg::*; #(
    parameter int MAX_WEIGHT = DEF_MAX_WEIGHT,
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // command channel
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [31:0]              i_random_word,
    // result channel
    output logic                          o_strobe,
    output logic [INDEX_BITS-1:0]         o_index_value,
    output logic [6:0]                    o_list_slot,
    output logic                          o_last,
    // APB configuration port
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]              pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int EW = ($clog2(MAX_WEIGHT + 1) > 8) ? $clog2(MAX_WEIGHT + 1) : 8;

    logic [7:0]            r_target_weight;
    logic [15:0]           r_index_range;

    logic                  w_cfg_wr;
    logic [EW-1:0]         w_weight_raw;
    logic [EW-1:0]         w_weight;
    logic [31:0]           w_range_ext;
    logic [INDEX_BITS-1:0] w_range;
    logic [INDEX_BITS-1:0] w_rd_data;
    t_store_req            w_req;

    // configuration registers; writes never touch the current list
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_weight <= RST_TARGET_WEIGHT;
            r_index_range   <= RST_INDEX_RANGE;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_TARGET_WEIGHT: r_target_weight <= pwdata[7:0];
                REG_INDEX_RANGE:   r_index_range   <= pwdata[15:0];
                default:           ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TARGET_WEIGHT: prdata = 32'(r_target_weight);
            REG_INDEX_RANGE:   prdata = 32'(r_index_range);
            default:           prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // weight of zero counts as one; anything above the store depth saturates
    assign w_weight_raw = EW'(r_target_weight);
    always_comb begin
        if (w_weight_raw == '0) begin
            w_weight = EW'(1);
        end else if (w_weight_raw > EW'(MAX_WEIGHT)) begin
            w_weight = EW'(MAX_WEIGHT);
        end else begin
            w_weight = w_weight_raw;
        end
    end

    // range held to the index width
    assign w_range_ext = 32'(r_index_range);
    assign w_range     = w_range_ext[INDEX_BITS-1:0];

    dirs_ctrl #(
        .MAX_WEIGHT (MAX_WEIGHT),
        .INDEX_BITS (INDEX_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_random_word (i_random_word),
        .i_range       (w_range),
        .i_weight      (w_weight),
        .i_rd_data     (w_rd_data),
        .o_req         (w_req),
        .o_busy        (busy),
        .o_strobe      (o_strobe),
        .o_index_value (o_index_value),
        .o_list_slot   (o_list_slot),
        .o_last        (o_last)
    );

    dirs_store #(
        .MAX_WEIGHT (MAX_WEIGHT),
        .INDEX_BITS (INDEX_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_req     (w_req),
        .o_rd_data (w_rd_data)
    );

endmodule

`default_nettype wire

// ===== rtl/core/dirs_store.sv =====
// Index store: one write port, one registered read port.
// Depends on dirs_pkg.
`default_nettype none

module dirs_store import dirs_pkg::*; #(
    parameter int MAX_WEIGHT = DEF_MAX_WEIGHT,
    parameter int INDEX_BITS = DEF_INDEX_BITS,
    localparam int AW = (MAX_WEIGHT > 1) ? $clog2(MAX_WEIGHT) : 1
) (
    input  wire logic                  i_clk,
    input  wire t_store_req            i_req,
    output logic [INDEX_BITS-1:0]      o_rd_data
);

    logic [INDEX_BITS-1:0] r_mem [MAX_WEIGHT];
    logic [INDEX_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[AW-1:0]] <= i_req.wdata[INDEX_BITS-1:0];
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr[AW-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/core/dirs_ctrl.sv =====
// Sequencer: masks and range-checks a word, scans the list with one comparator,
// appends and reports accepted indices. Depends on dirs_pkg and the defines header.
`default_nettype none
`include "distinct_index_rejection_sampler_defines.svh"

module dirs_ctrl import dirs_pkg::*; #(
    parameter int MAX_WEIGHT = DEF_MAX_WEIGHT,
    parameter int INDEX_BITS = DEF_INDEX_BITS,
    localparam int CW = (MAX_WEIGHT > 1) ? $clog2(MAX_WEIGHT) : 1,
    localparam int EW = ($clog2(MAX_WEIGHT + 1) > 8) ? $clog2(MAX_WEIGHT + 1) : 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [31:0]           i_random_word,
    input  wire logic [INDEX_BITS-1:0] i_range,
    input  wire logic [EW-1:0]         i_weight,
    input  wire logic [INDEX_BITS-1:0] i_rd_data,
    output t_store_req                 o_req,
    output logic                       o_busy,
    output logic                       o_strobe,
    output logic [INDEX_BITS-1:0]      o_index_value,
    output logic [6:0]                 o_list_slot,
    output logic                       o_last
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_ACCEPT = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [INDEX_BITS-1:0] r_cand;
    logic [CW-1:0]         r_ptr;
    logic                  r_pend;
    logic [CW-1:0]         r_count;
    logic                  r_strobe;
    logic                  r_last;
    logic [INDEX_BITS-1:0] r_out_index;
    logic [6:0]            r_out_slot;

    logic [INDEX_BITS-1:0] w_mask;
    logic [INDEX_BITS-1:0] w_cand;
    logic                  w_take;
    logic                  w_in_range;
    logic                  w_issue;
    logic                  w_hit;
    logic [EW-1:0]         w_cnt_inc;
    logic                  w_last;
    logic [31:0]           w_slot_ext;

    // mask of ones up to the top set bit of the range
    always_comb begin
        for (int b = 0; b < INDEX_BITS; b++) begin
            w_mask[b] = |(i_range >> b);
        end
    end

    assign w_cand     = i_random_word[INDEX_BITS-1:0] & w_mask;
    assign w_in_range = (w_cand < i_range);
    assign w_take     = i_start && (r_state == S_IDLE);
    assign w_issue    = (r_ptr != r_count);
    // the shared comparator
    assign w_hit      = r_pend && (i_rd_data == r_cand);
    assign w_cnt_inc  = EW'(r_count) + EW'(1);
    assign w_last     = (w_cnt_inc >= i_weight);
    assign w_slot_ext = 32'(r_count);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_take && w_in_range) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_state = S_IDLE;
                end else if (!w_issue) begin
                    n_state = S_ACCEPT;
                end
            end
            S_ACCEPT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ptr    <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_ACCEPT);
            if (r_state == S_IDLE) begin
                r_ptr  <= '0;
                r_pend <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_pend <= w_issue;
                if (w_issue) begin
                    r_ptr <= r_ptr + CW'(1);
                end
            end
            if (r_state == S_ACCEPT) begin
                r_last  <= w_last;
                r_count <= w_last ? '0 : w_cnt_inc[CW-1:0];
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cand <= w_cand;
        end
        if (r_state == S_ACCEPT) begin
            r_out_index <= r_cand;
            r_out_slot  <= w_slot_ext[6:0];
        end
    end

    always_comb begin
        o_req       = '0;
        o_req.we    = (r_state == S_ACCEPT);
        o_req.waddr = ADDR_MAX_BITS'(r_count);
        o_req.wdata = DATA_MAX_BITS'(r_cand);
        o_req.re    = (r_state == S_SCAN) && w_issue;
        o_req.raddr = ADDR_MAX_BITS'(r_ptr);
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_index_value = r_out_index;
    assign o_list_slot   = r_out_slot;
    assign o_last        = r_last;

    `DIRS_ASSERT(a_strobe_after_accept, i_clk, i_rst_n, r_strobe |-> $past(r_state == S_ACCEPT), "strobe without accept")
    `DIRS_ASSERT(a_count_bound, i_clk, i_rst_n, (32'(r_count) < MAX_WEIGHT), "list count beyond capacity")
    `DIRS_ASSERT(a_ptr_bound, i_clk, i_rst_n, (r_state == S_SCAN) |-> (r_ptr <= r_count), "scan pointer past list end")
    `DIRS_ASSERT(a_last_restarts, i_clk, i_rst_n, (r_strobe && r_last) |-> (r_count == '0), "list not restarted after last")

endmodule

`default_nettype wire

// ===== bench/distinct_index_rejection_sampler_test.sv =====
// Self-checking bench for distinct_index_rejection_sampler: a directed table, then
// random phases with APB reconfiguration, checked against a cycle-free predictor.
// Depends on dirs_pkg and the sampler RTL.
`timescale 1ns / 1ps

module distinct_index_rejection_sampler_test import dirs_pkg::*;;

    localparam int MAX_W = DEF_MAX_WEIGHT;

    // what became of one accepted command transaction
    typedef enum logic [1:0] {WORD_TAKEN, WORD_REPEAT, WORD_OUTSIDE} t_word_fate;

    // directed rows: register write, typed hit, typed drop, or predictor only
    typedef enum logic [1:0] {ROW_CONFIG, ROW_HIT, ROW_MISS, ROW_OPEN} t_row_kind;

    typedef struct packed {
        logic [15:0] idx;
        logic [6:0]  slot;
        logic        fin;
    } t_index_out;

    typedef struct packed {
        t_row_kind   kind;
        logic        sel;
        logic [31:0] val;
        t_index_out  want;
    } t_plan_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_random_word = '0;
    logic        o_strobe;
    logic [15:0] o_index_value;
    logic [6:0]  o_list_slot;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    distinct_index_rejection_sampler u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_random_word (i_random_word),
        .o_strobe      (o_strobe),
        .o_index_value (o_index_value),
        .o_list_slot   (o_list_slot),
        .o_last        (o_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state: our own copy of the registers and the current list.
    logic [7:0]  weight_reg = RST_TARGET_WEIGHT;
    logic [15:0] range_reg  = RST_INDEX_RANGE;
    logic [15:0] list_idx [MAX_W];
    int          list_fill = 0;

    t_index_out  due_indices [$];   // accepted indices still to be strobed
    t_plan_row   plan [$];
    int          fail_count = 0;
    bit          cmd_live = 1'b0;   // start currently held high by the bench
    bit          quiet = 1'b0;      // phase with no gaps between commands

    // Mask to the bit length of the range, drop anything not below it, drop
    // repeats within the current list, otherwise take the next slot.
    function automatic t_word_fate sample_index(input logic [31:0] word,
                                                output t_index_out res);
        int          lim;
        int          len;
        int          w;
        int          n;
        logic [31:0] cand;
        lim = int'(range_reg);
        len = 0;
        for (int b = 0; b < 16; b++)
            if (lim[b]) len = b + 1;
        cand = word & ((32'd1 << len) - 32'd1);
        res = '0;
        if (cand >= 32'(lim)) return WORD_OUTSIDE;
        // zero weight means one; anything past the store depth saturates
        w = int'(weight_reg);
        if (w == 0) w = 1;
        if (w > MAX_W) w = MAX_W;
        n = list_fill;
        if (n >= MAX_W) n = 0;
        for (int i = 0; i < n; i++)
            if (list_idx[i] == cand[15:0]) return WORD_REPEAT;
        list_idx[n] = cand[15:0];
        res.idx  = cand[15:0];
        res.slot = n[6:0];
        res.fin  = (n + 1 >= w);   // also catches a weight lowered mid-list
        list_fill = res.fin ? 0 : n + 1;
        return WORD_TAKEN;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // One command transaction: hold start until taken, predict, then maybe idle.
    // start is left high across back-to-back words so it never gets two updates
    // in one step.
    task automatic issue_word(input logic [31:0] word, output t_word_fate fate,
                              output t_index_out got);
        int gap;
        if (!cmd_live) start <= 1'b1;
        cmd_live = 1'b1;
        i_random_word <= word;
        do @(posedge i_clk); while (busy);
        fate = sample_index(word, got);
        if (fate == WORD_TAKEN) due_indices.push_back(got);
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            cmd_live = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Wait for the block to go idle: every index strobed and no duplicate
    // search still running, then a short margin for the result pipeline.
    task automatic settle();
        if (cmd_live) begin
            start <= 1'b0;
            cmd_live = 1'b0;
        end
        do @(posedge i_clk); while (due_indices.size() != 0 || busy);
        repeat (3) @(posedge i_clk);
    endtask

    // APB write then read-back of the same register, only while idle.
    task automatic write_reg(input logic sel, input logic [31:0] val);
        logic [31:0] want;
        logic [31:0] seen;
        settle();
        want = (sel == REG_TARGET_WEIGHT) ? {24'd0, val[7:0]} : {16'd0, val[15:0]};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (sel == REG_TARGET_WEIGHT) weight_reg = val[7:0];
        else range_reg = val[15:0];
        // straight into the setup phase of the read
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        seen = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (seen !== want) begin
            $error("prdata: reg %0d expected %0h got %0h", sel, want, seen);
            fail_count++;
        end
    endtask

    task automatic add_row(input t_row_kind kind, input logic sel, input logic [31:0] val,
                           input int idx, input int slot, input bit fin);
        t_plan_row r;
        r.kind = kind;
        r.sel  = sel;
        r.val  = val;
        r.want = '{idx: 16'(idx), slot: 7'(slot), fin: fin};
        plan.push_back(r);
    endtask

    // Result side: the strobe cannot be held off, so every strobe is a transaction.
    t_index_out head;
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (due_indices.size() == 0) begin
                $error("unexpected result: index_value %0d list_slot %0d last %0b",
                       o_index_value, o_list_slot, o_last);
                fail_count++;
            end else begin
                head = due_indices.pop_front();
                if (o_index_value !== head.idx) begin
                    $error("index_value: expected %0d got %0d", head.idx, o_index_value);
                    fail_count++;
                end
                if (o_list_slot !== head.slot) begin
                    $error("list_slot: expected %0d got %0d", head.slot, o_list_slot);
                    fail_count++;
                end
                if (o_last !== head.fin) begin
                    $error("last: expected %0b got %0b", head.fin, o_last);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("distinct_index_rejection_sampler_test: errors");
        $finish;
    end

    initial begin
        t_word_fate  fate;
        t_index_out  got;
        t_plan_row   r;
        int          counted;
        int          burst;
        int          pick;
        logic [31:0] mask;
        logic [31:0] word;
        logic [15:0] cand;
        logic [7:0]  wsel;
        logic [15:0] rsel;

        // Directed table: reset values first, then the corner cases.
        add_row(ROW_HIT,  1'b0, 32'h0000_0000, 0, 0, 1'b0);      // first index after reset
        add_row(ROW_MISS, 1'b0, 32'hFFFF_C000, 0, 0, 1'b0);      // masks to 0: repeat
        add_row(ROW_HIT,  1'b0, 32'd10162, 10162, 1, 1'b0);      // top of range
        add_row(ROW_MISS, 1'b0, 32'd10163, 0, 0, 1'b0);          // equals range
        add_row(ROW_MISS, 1'b0, 32'hFFFF_FFFF, 0, 0, 1'b0);      // mask all ones, above range
        add_row(ROW_OPEN, 1'b0, 32'h5A5A_1234, 0, 0, 1'b0);
        add_row(ROW_CONFIG, REG_TARGET_WEIGHT, 32'd2, 0, 0, 1'b0); // weight below fill
        add_row(ROW_HIT,  1'b0, 32'd5, 5, 3, 1'b1);              // overshoot closes list
        add_row(ROW_HIT,  1'b0, 32'h8000_0005, 5, 0, 1'b0);      // fresh list takes 5 again
        add_row(ROW_MISS, 1'b0, 32'h1234_0005, 0, 0, 1'b0);
        add_row(ROW_HIT,  1'b0, 32'd7, 7, 1, 1'b1);
        add_row(ROW_CONFIG, REG_TARGET_WEIGHT, 32'd0, 0, 0, 1'b0); // zero weight acts as one
        add_row(ROW_HIT,  1'b0, 32'd9, 9, 0, 1'b1);
        add_row(ROW_HIT,  1'b0, 32'd9, 9, 0, 1'b1);
        add_row(ROW_CONFIG, REG_TARGET_WEIGHT, 32'hFFFF_FFFF, 0, 0, 1'b0); // saturates
        add_row(ROW_CONFIG, REG_INDEX_RANGE, 32'd1, 0, 0, 1'b0);   // only index 0
        add_row(ROW_HIT,  1'b0, 32'hFFFF_FFFE, 0, 0, 1'b0);
        add_row(ROW_MISS, 1'b0, 32'd1, 0, 0, 1'b0);
        add_row(ROW_MISS, 1'b0, 32'd0, 0, 0, 1'b0);
        add_row(ROW_CONFIG, REG_INDEX_RANGE, 32'd0, 0, 0, 1'b0);   // rejects everything
        add_row(ROW_MISS, 1'b0, 32'hFFFF_FFFF, 0, 0, 1'b0);
        add_row(ROW_MISS, 1'b0, 32'd0, 0, 0, 1'b0);
        add_row(ROW_CONFIG, REG_INDEX_RANGE, 32'hFFFF_FFFF, 0, 0, 1'b0); // 65535
        add_row(ROW_MISS, 1'b0, 32'hFFFF_FFFF, 0, 0, 1'b0);
        add_row(ROW_HIT,  1'b0, 32'h0000_FFFE, 65534, 1, 1'b0);
        add_row(ROW_OPEN, 1'b0, 32'hABCD_0003, 0, 0, 1'b0);
        add_row(ROW_CONFIG, REG_TARGET_WEIGHT, 32'd1, 0, 0, 1'b0);
        add_row(ROW_CONFIG, REG_INDEX_RANGE, 32'd2, 0, 0, 1'b0);
        add_row(ROW_MISS, 1'b0, 32'd2, 0, 0, 1'b0);
        add_row(ROW_HIT,  1'b0, 32'hFFFF_FFFD, 1, 3, 1'b1);
        add_row(ROW_OPEN, 1'b0, 32'h0000_0000, 0, 0, 1'b0);

        for (int i = 0; i < MAX_W; i++) list_idx[i] = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            r = plan[i];
            if (r.kind == ROW_CONFIG) begin
                write_reg(r.sel, r.val);
            end else begin
                issue_word(r.val, fate, got);
                // typed rows also cross-check the predictor
                if ((r.kind == ROW_HIT && (fate != WORD_TAKEN || got != r.want)) ||
                    (r.kind == ROW_MISS && fate == WORD_TAKEN)) begin
                    $error("directed row %0d: predictor disagrees with table", i);
                    fail_count++;
                end
            end
        end

        // Random phases: new settings, then a burst of words that are mostly
        // in range, a good share of repeats from the current list, the rest noise.
        counted = 0;
        while (counted < 750) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: wsel = 8'd1;
                1, 2: wsel = 8'd128;
                3: wsel = ($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom_range(129, 255));
                default: wsel = 8'($urandom_range(1, 40));
            endcase
            pick = $urandom_range(0, 19);
            case (pick)
                0: rsel = 16'($urandom_range(0, 1));
                1, 2: rsel = 16'd2;
                3, 4, 5, 6: rsel = 16'($urandom_range(3, 200));
                7, 8, 9: rsel = 16'hFFFF;
                default: rsel = 16'($urandom_range(2, 65535));
            endcase
            if ($urandom_range(0, 1) != 0) begin
                write_reg(REG_TARGET_WEIGHT, {$urandom() & 32'hFFFF_FF00} | 32'(wsel));
                write_reg(REG_INDEX_RANGE, {$urandom() & 32'hFFFF_0000} | 32'(rsel));
            end else begin
                write_reg(REG_INDEX_RANGE, {$urandom() & 32'hFFFF_0000} | 32'(rsel));
                write_reg(REG_TARGET_WEIGHT, {$urandom() & 32'hFFFF_FF00} | 32'(wsel));
            end
            quiet = ($urandom_range(0, 3) == 0);
            // a hopeless range gets only a short burst
            burst = (range_reg < 16'd2) ? $urandom_range(3, 8) : $urandom_range(20, 60);

            mask = 32'd0;
            for (int b = 0; b < 16; b++)
                if (range_reg[b]) mask = (32'd1 << (b + 1)) - 32'd1;

            repeat (burst) begin
                pick = $urandom_range(0, 99);
                if (range_reg < 16'd2 || pick >= 85) begin
                    word = $urandom();
                end else if (pick >= 60 && list_fill > 0) begin
                    cand = list_idx[$urandom_range(0, list_fill - 1)];
                    word = ($urandom() & ~mask) | 32'(cand);
                end else begin
                    cand = 16'($urandom_range(0, int'(range_reg) - 1));
                    word = ($urandom() & ~mask) | 32'(cand);
                end
                issue_word(word, fate, got);
                counted++;
            end
        end

        settle();
        if (fail_count == 0)
            $display("distinct_index_rejection_sampler_test: clean");
        else
            $display("distinct_index_rejection_sampler_test: errors");
        $finish;
    end

endmodule
